FILE: sv/gia_pkg.sv
package gia_pkg;

    // Default sizes of the slot table and its fields
    localparam int DEF_MAX_SLOTS    = 1024;
    localparam int DEF_VERSION_BITS = 16;
    localparam int DEF_MASK_BITS    = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_RESERVE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_UPDATE  = 2'd2
    } gia_req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEAD = 2'd2
    } gia_status_t;

    // Memory port controls from the sequencer to the table store
    typedef struct packed {
        logic rd_en;
        logic slot_we;
        logic mask_we;
    } gia_mem_ctl_t;

endpackage

FILE: sv/gia_req_if.sv
interface gia_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  entity_id;
    logic [15:0] entity_version;
    logic [31:0] mask_changes;
    logic        subtract_flag;

    modport source (
        output valid, req_type, entity_id, entity_version, mask_changes, subtract_flag,
        input  ready
    );

    modport sink (
        input  valid, req_type, entity_id, entity_version, mask_changes, subtract_flag,
        output ready
    );
endinterface

FILE: sv/gia_rsp_if.sv
interface gia_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  out_id;
    logic [15:0] out_version;
    logic        was_alive;
    logic [31:0] mask_out;

    modport source (
        output valid, status, out_id, out_version, was_alive, mask_out,
        input  ready
    );

    modport sink (
        input  valid, status, out_id, out_version, was_alive, mask_out,
        output ready
    );
endinterface

FILE: sv/gia_store.sv
module gia_store #(
    parameter int DEPTH = gia_pkg::DEF_MAX_SLOTS,
    parameter int IW    = $clog2(gia_pkg::DEF_MAX_SLOTS),
    parameter int SW    = $clog2(gia_pkg::DEF_MAX_SLOTS) + gia_pkg::DEF_VERSION_BITS,
    parameter int MW    = gia_pkg::DEF_MASK_BITS
) (
    input  logic                 clk,
    input  gia_pkg::gia_mem_ctl_t ctl,
    input  logic [IW-1:0]        addr,
    input  logic [SW-1:0]        slot_wdata,
    input  logic [MW-1:0]        mask_wdata,
    output logic [SW-1:0]        slot_rdata,
    output logic [MW-1:0]        mask_rdata
);
    import gia_pkg::*;

    // Slot entries (link or own index, version) and component masks
    logic [SW-1:0] slot_mem [DEPTH];
    logic [MW-1:0] mask_mem [DEPTH];

    // Write slot entry, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.slot_we)
        begin
            slot_mem[addr] <= slot_wdata;
        end
        if (ctl.rd_en)
        begin
            slot_rdata <= slot_mem[addr];
        end
    end

    // Write mask, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.mask_we)
        begin
            mask_mem[addr] <= mask_wdata;
        end
        if (ctl.rd_en)
        begin
            mask_rdata <= mask_mem[addr];
        end
    end

endmodule

FILE: sv/generational_id_allocator.sv
// Latency: the result register loads at the edge after the request transfer, and the
// result is held on rsp until it transfers.
// Throughput: a new request is not taken until the read-modify-write of the slot and
// mask memories is done (read on transfer, write back in the following cycle).
// Reset: free-list head, free count and used-slot count clear to zero; the
// tables are not cleared, slots at or above the used count are never trusted.
module generational_id_allocator #(
    parameter int MAX_SLOTS    = gia_pkg::DEF_MAX_SLOTS,
    parameter int VERSION_BITS = gia_pkg::DEF_VERSION_BITS,
    parameter int MASK_BITS    = gia_pkg::DEF_MASK_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    gia_req_if.sink   req,
    gia_rsp_if.source rsp
);
    import gia_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int VW = VERSION_BITS;
    localparam int MW = MASK_BITS;
    localparam int SW = IW + VW;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] free_count_reg, free_count_next;
    logic [CW-1:0] used_slots_reg, used_slots_next;

    // Captured request
    logic [1:0]    type_reg, type_next;
    logic [9:0]    id_reg, id_next;
    logic [15:0]   ver_reg, ver_next;
    logic [VW-1:0] ver_cmp_reg, ver_cmp_next;
    logic [MW-1:0] chg_reg, chg_next;
    logic          sub_reg, sub_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic          in_range_reg, in_range_next;
    logic          from_list_reg, from_list_next;
    logic          fresh_reg, fresh_next;

    // Result register
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [9:0]    out_id_reg, out_id_next;
    logic [15:0]   out_ver_reg, out_ver_next;
    logic          alive_reg, alive_next;
    logic [MW-1:0] mask_out_reg, mask_out_next;

    // Memory port
    gia_mem_ctl_t  mem_ctl;
    logic [IW-1:0] mem_addr;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic [MW-1:0] mask_wdata, mask_rdata;

    logic          accept;
    logic [31:0]   id_wide;
    logic [IW-1:0] rd_addr;
    logic          from_list, fresh, in_range;
    logic [IW-1:0] link;
    logic [VW-1:0] stored_ver;
    logic          alive;
    logic [MW-1:0] new_mask;

    gia_store #(
        .DEPTH (MAX_SLOTS),
        .IW    (IW),
        .SW    (SW),
        .MW    (MW)
    ) u_store (
        .clk        (clk),
        .ctl        (mem_ctl),
        .addr       (mem_addr),
        .slot_wdata (slot_wdata),
        .mask_wdata (mask_wdata),
        .slot_rdata (slot_rdata),
        .mask_rdata (mask_rdata)
    );

    // Take a request only when idle and the result register is free or draining
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // Decode the incoming request and pick the entry to read
    assign id_wide   = 32'(req.entity_id);
    assign in_range  = (id_wide < 32'(used_slots_reg)) && (id_wide < 32'(MAX_SLOTS));
    assign from_list = (free_count_reg != '0);
    assign fresh     = !from_list && (used_slots_reg < CW'(MAX_SLOTS));

    always_comb
    begin
        if (req.req_type == REQ_RESERVE)
        begin
            rd_addr = from_list ? free_head_reg : used_slots_reg[IW-1:0];
        end
        else
        begin
            rd_addr = id_wide[IW-1:0];
        end
    end

    // Liveness and mask update from the entry just read
    assign link       = slot_rdata[SW-1:VW];
    assign stored_ver = slot_rdata[VW-1:0];
    assign alive      = in_range_reg && (32'(link) == 32'(id_reg)) && (stored_ver == ver_cmp_reg);
    assign new_mask   = sub_reg ? (mask_rdata & ~chg_reg) : (mask_rdata | chg_reg);

    assign mem_addr = (state_reg == S_EXEC) ? addr_reg : rd_addr;

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        used_slots_next = used_slots_reg;
        type_next       = type_reg;
        id_next         = id_reg;
        ver_next        = ver_reg;
        ver_cmp_next    = ver_cmp_reg;
        chg_next        = chg_reg;
        sub_next        = sub_reg;
        addr_next       = addr_reg;
        in_range_next   = in_range_reg;
        from_list_next  = from_list_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        status_next     = status_reg;
        out_id_next     = out_id_reg;
        out_ver_next    = out_ver_reg;
        alive_next      = alive_reg;
        mask_out_next   = mask_out_reg;
        mem_ctl         = '0;
        slot_wdata      = '0;
        mask_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Capture the request and issue the read
                if (accept)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    type_next      = req.req_type;
                    id_next        = req.entity_id;
                    ver_next       = req.entity_version;
                    ver_cmp_next   = VW'(req.entity_version);
                    chg_next       = MW'(req.mask_changes);
                    sub_next       = req.subtract_flag;
                    addr_next      = rd_addr;
                    in_range_next  = in_range;
                    from_list_next = from_list;
                    fresh_next     = fresh;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Modify, write back and load the result
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                out_id_next    = id_reg;
                out_ver_next   = ver_reg;
                alive_next     = alive;
                mask_out_next  = '0;
                case (type_reg)
                    REQ_RESERVE:
                    begin
                        alive_next = 1'b0;
                        if (from_list_reg)
                        begin
                            mem_ctl.slot_we = 1'b1;
                            slot_wdata      = {addr_reg, stored_ver};
                            free_head_next  = link;
                            free_count_next = free_count_reg - CW'(1);
                            out_id_next     = 10'(addr_reg);
                            out_ver_next    = 16'(stored_ver);
                            mask_out_next   = mask_rdata;
                        end
                        else if (fresh_reg)
                        begin
                            mem_ctl.slot_we = 1'b1;
                            mem_ctl.mask_we = 1'b1;
                            slot_wdata      = {addr_reg, {VW{1'b0}}};
                            used_slots_next = used_slots_reg + CW'(1);
                            out_id_next     = 10'(addr_reg);
                            out_ver_next    = '0;
                        end
                        else
                        begin
                            status_next  = ST_FULL;
                            out_id_next  = '0;
                            out_ver_next = '0;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (alive)
                        begin
                            mem_ctl.slot_we = 1'b1;
                            mem_ctl.mask_we = 1'b1;
                            slot_wdata      = {free_head_reg, stored_ver + VW'(1)};
                            free_head_next  = addr_reg;
                            free_count_next = free_count_reg + CW'(1);
                        end
                        else
                        begin
                            status_next = ST_DEAD;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if (alive)
                        begin
                            mem_ctl.mask_we = 1'b1;
                            mask_wdata      = new_mask;
                            mask_out_next   = new_mask;
                        end
                        else
                        begin
                            status_next = ST_DEAD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_DEAD;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, counters, captured request and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            used_slots_reg <= '0;
            type_reg       <= '0;
            id_reg         <= '0;
            ver_reg        <= '0;
            ver_cmp_reg    <= '0;
            chg_reg        <= '0;
            sub_reg        <= 1'b0;
            addr_reg       <= '0;
            in_range_reg   <= 1'b0;
            from_list_reg  <= 1'b0;
            fresh_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            out_id_reg     <= '0;
            out_ver_reg    <= '0;
            alive_reg      <= 1'b0;
            mask_out_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            used_slots_reg <= used_slots_next;
            type_reg       <= type_next;
            id_reg         <= id_next;
            ver_reg        <= ver_next;
            ver_cmp_reg    <= ver_cmp_next;
            chg_reg        <= chg_next;
            sub_reg        <= sub_next;
            addr_reg       <= addr_next;
            in_range_reg   <= in_range_next;
            from_list_reg  <= from_list_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            out_id_reg     <= out_id_next;
            out_ver_reg    <= out_ver_next;
            alive_reg      <= alive_next;
            mask_out_reg   <= mask_out_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_id      = out_id_reg;
    assign rsp.out_version = out_ver_reg;
    assign rsp.was_alive   = alive_reg;
    assign rsp.mask_out    = 32'(mask_out_reg);

    // Used-slot count never passes the table size
    a_used_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        used_slots_reg <= CW'(MAX_SLOTS))
        else $error("used slots exceed table size");

    // A new result appears only after a request transfer
    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept, 2))
        else $error("result without a request");

    // Memory writes happen only in the write-back cycle
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.slot_we || mem_ctl.mask_we) |-> (state_reg == S_EXEC))
        else $error("memory write outside write-back");

    // Full is reported only when no slot is left
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && status_next == ST_FULL)
            |-> (free_count_reg == '0 && used_slots_reg == CW'(MAX_SLOTS)))
        else $error("full reported with slots left");

    // A transfer is followed by the write-back state, in which no new transfer is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC && !req.ready))
        else $error("request overlaps write-back");

endmodule
